>>> rtl/base_presence_debouncer_core_macros.svh
// ----------------------------------------------------------------------------
// base_presence_debouncer_core_macros.svh
// Assertion macros used by the checker file of the presence debouncer.
// ----------------------------------------------------------------------------
`ifndef BASE_PRESENCE_DEBOUNCER_CORE_MACROS_SVH
`define BASE_PRESENCE_DEBOUNCER_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication built on the macro above.
`define BPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `BPD_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> rtl/bpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_pkg
// Types and constants of the base presence debouncer.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Reset values of the timing registers, in ms ticks
  localparam int unsigned ATTACH_RESET = 350;
  localparam int unsigned DETACH_RESET = 20;
  localparam int unsigned WINDOW_RESET = 500;

  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_EDGE         = 3'd1,
    CMD_POWER_UP     = 3'd2,
    CMD_POWER_DOWN   = 3'd3,
    CMD_FORCE_ATTACH = 3'd4,
    CMD_FORCE_DETACH = 3'd5,
    CMD_FORCE_RESET  = 3'd6,
    CMD_LID          = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNKNOWN      = 2'd0,
    ST_DISCONNECTED = 2'd1,
    ST_CONNECTED    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACH = 2'd0,
    REG_DETACH = 2'd1,
    REG_WINDOW = 2'd2
  } reg_idx_e;

endpackage

>>> rtl/bpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_if
// Valid/ready channels of the debouncer: event in, result out, register write.
// ----------------------------------------------------------------------------
interface bpd_in_if ();
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       presence_level;
  logic       lid_up;

  modport source (output valid, command, presence_level, lid_up, input ready);
  modport sink   (input valid, command, presence_level, lid_up, output ready);
endinterface

interface bpd_out_if ();
  logic       valid;
  logic       ready;
  logic [1:0] dock_state;
  logic       base_power_enable;
  logic       standalone;
  logic       status_changed;

  modport source (output valid, dock_state, base_power_enable, standalone,
                  status_changed, input ready);
  modport sink   (input valid, dock_state, base_power_enable, standalone,
                  status_changed, output ready);
endinterface

interface bpd_cfg_if import bpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bpd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_cfg_regs
// Timing register file: attach delay, detach delay, retry window.
// ----------------------------------------------------------------------------
module bpd_cfg_regs import bpd_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bpd_cfg_if.sink                cfg_i,
  output logic [TIMER_WIDTH-1:0] attach_o,
  output logic [TIMER_WIDTH-1:0] detach_o,
  output logic [TIMER_WIDTH-1:0] window_o
);

  logic [TIMER_WIDTH-1:0] attach_q, detach_q, window_q;
  logic [TIMER_WIDTH-1:0] wdata;
  logic                   wr_en;

  // Values are cut or zero-extended to the timer width on write
  if (TIMER_WIDTH > CFG_DATA_W) begin : g_ext
    assign wdata = {{(TIMER_WIDTH - CFG_DATA_W){1'b0}}, cfg_i.data};
  end else if (TIMER_WIDTH == CFG_DATA_W) begin : g_same
    assign wdata = cfg_i.data;
  end else begin : g_trunc
    assign wdata = cfg_i.data[TIMER_WIDTH-1:0];
  end

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attach_q <= TIMER_WIDTH'(ATTACH_RESET);
      detach_q <= TIMER_WIDTH'(DETACH_RESET);
      window_q <= TIMER_WIDTH'(WINDOW_RESET);
    end else if (wr_en) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_ATTACH: attach_q <= wdata;
        REG_DETACH: detach_q <= wdata;
        REG_WINDOW: window_q <= wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign attach_o = attach_q;
  assign detach_o = detach_q;
  assign window_o = window_q;

endmodule

>>> rtl/base_presence_debouncer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_presence_debouncer_core
// Asymmetric debounce of a detachable-base presence pin, one event per item.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       payload
//  -------  ---  --------------  ----------------------------------------------
//  in_i     in   valid / ready   command, presence_level, lid_up
//  out_o    out  valid / ready   dock_state, base_power_enable, standalone,
//                                status_changed
//  cfg_i    in   valid / ready   index, data (ready is always high)
//
//  One item per cycle while results are taken. The accepted event updates the
//  debounce state and the result register in the same edge; the result shows
//  on out_o the next cycle. The result register is the only buffer: in_i.ready
//  drops only while a result sits unread with out_o.ready low. Loop: state
//  regs -> event decode -> state regs, one timer decrement/compare deep.
//  Reset clears status to unknown, detection off, no check pending, both
//  countdowns zero, timing registers to 350 / 20 / 500 ms.
// ----------------------------------------------------------------------------
module base_presence_debouncer_core import bpd_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpd_in_if.sink    in_i,
  bpd_out_if.source out_o,
  bpd_cfg_if.sink   cfg_i
);

  localparam logic [TIMER_WIDTH-1:0] TZERO = '0;
  localparam logic [TIMER_WIDTH-1:0] TONE  = TIMER_WIDTH'(1);

  // Timing registers
  logic [TIMER_WIDTH-1:0] attach_ticks, detach_ticks, window_ticks;

  bpd_cfg_regs #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .attach_o(attach_ticks),
    .detach_o(detach_ticks),
    .window_o(window_ticks)
  );

  // Debounce state
  status_e                status_q, status_d;
  logic                   detect_q, detect_d;
  logic                   armed_q, armed_d;
  logic                   pending_q, pending_d;
  logic [TIMER_WIDTH-1:0] check_q, check_d;
  logic [TIMER_WIDTH-1:0] retry_q, retry_d;

  // Result register
  logic    out_valid_q, out_valid_d;
  status_e res_status_q;
  logic    res_changed_q;

  logic    accept;
  cmd_e    cmd;
  status_e pin_status;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.command);
  assign pin_status = in_i.presence_level ? ST_CONNECTED : ST_DISCONNECTED;

  // Event decode. A status write inside an open retry window restarts the
  // check timer with the time left in the window; a disable drops the check.
  always_comb begin
    status_d  = status_q;
    detect_d  = detect_q;
    armed_d   = armed_q;
    pending_d = pending_q;
    check_d   = check_q;
    retry_d   = retry_q;

    unique case (cmd)
      CMD_TICK: begin
        if (retry_q != TZERO) begin
          retry_d = retry_q - TONE;
        end
        if (pending_q) begin
          if (check_q <= TONE) begin
            // check fires
            check_d   = TZERO;
            pending_d = 1'b0;
            if (detect_q) begin
              status_d = pin_status;
              armed_d  = 1'b1;
              if (retry_d != TZERO) begin
                pending_d = 1'b1;
                check_d   = retry_d;
              end
            end
          end else begin
            check_d = check_q - TONE;
          end
        end
      end
      CMD_EDGE: begin
        if (armed_q) begin
          armed_d   = 1'b0;
          pending_d = 1'b1;
          check_d   = (status_q == ST_CONNECTED) ? detach_ticks : attach_ticks;
          retry_d   = window_ticks;
        end
      end
      CMD_FORCE_ATTACH, CMD_FORCE_DETACH: begin
        // detection off, then the forced status (may restart the timer)
        detect_d  = 1'b0;
        armed_d   = 1'b0;
        status_d  = (cmd == CMD_FORCE_ATTACH) ? ST_CONNECTED : ST_DISCONNECTED;
        pending_d = (retry_q != TZERO);
        check_d   = retry_q;
      end
      CMD_POWER_UP, CMD_POWER_DOWN, CMD_FORCE_RESET, CMD_LID: begin
        if (cmd == CMD_POWER_UP || cmd == CMD_FORCE_RESET ||
            (cmd == CMD_LID && in_i.lid_up)) begin
          detect_d = 1'b1;
          armed_d  = 1'b1;
          status_d = pin_status;
          if (retry_q != TZERO) begin
            pending_d = 1'b1;
            check_d   = retry_q;
          end
        end else begin
          // disable: status unknown, pending check dropped
          detect_d  = 1'b0;
          armed_d   = 1'b0;
          status_d  = ST_UNKNOWN;
          pending_d = 1'b0;
          check_d   = TZERO;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= ST_UNKNOWN;
      detect_q    <= 1'b0;
      armed_q     <= 1'b0;
      pending_q   <= 1'b0;
      check_q     <= '0;
      retry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        status_q  <= status_d;
        detect_q  <= detect_d;
        armed_q   <= armed_d;
        pending_q <= pending_d;
        check_q   <= check_d;
        retry_q   <= retry_d;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q  <= status_d;
      res_changed_q <= (status_d != status_q);
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.dock_state        = res_status_q;
  assign out_o.base_power_enable = (res_status_q == ST_CONNECTED);
  assign out_o.standalone        = (res_status_q != ST_CONNECTED);
  assign out_o.status_changed    = res_changed_q;

endmodule

>>> rtl/bpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks of the presence debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`include "base_presence_debouncer_core_macros.svh"

module bpd_checker import bpd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [2:0] in_command_i,
  input logic       in_lid_up_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_dock_state_i,
  input logic       out_power_enable_i,
  input logic       out_standalone_i
);

  logic in_fire;
  logic disable_evt;

  assign in_fire     = in_valid_i && in_ready_i;
  assign disable_evt = (in_command_i == CMD_POWER_DOWN) ||
                       ((in_command_i == CMD_LID) && !in_lid_up_i);

  `BPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_dock_state_i),
                   "result dropped or changed while stalled")

  `BPD_ASSERT(a_ready_free, clk_i, rst_ni, !out_valid_i |-> in_ready_i,
              "input stalled with empty result register")

  `BPD_ASSERT(a_power_mode, clk_i, rst_ni,
              out_valid_i |-> ((out_power_enable_i == (out_dock_state_i == ST_CONNECTED))
                               && (out_standalone_i == !out_power_enable_i)),
              "power enable / standalone flag disagree with status")

  `BPD_ASSERT_NEXT(a_disable_unknown, clk_i, rst_ni, in_fire && disable_evt,
                   out_valid_i && (out_dock_state_i == ST_UNKNOWN),
                   "detection disable did not report unknown status")

endmodule

bind base_presence_debouncer_core bpd_checker u_bpd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_command_i      (in_i.command),
  .in_lid_up_i       (in_i.lid_up),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_dock_state_i  (out_o.dock_state),
  .out_power_enable_i(out_o.base_power_enable),
  .out_standalone_i  (out_o.standalone)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base presence debouncer core. A short table
// of events (obvious results typed in, the rest predicted) is followed by
// random event streams under several timing settings. Both channel sides
// idle at random. Every result is checked against its typed-in value or
// an in-bench debounce model.
// ----------------------------------------------------------------------------
module tb_top;
  import bpd_pkg::*;

  localparam int unsigned LIMIT       = 400000;  // cycles before giving up
  localparam int unsigned PHASE_ITEMS = 165;     // random items per setting
  localparam int unsigned NUM_PHASES  = 7;

  // Index past the end of the register list, writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] dock_state;
    logic       power_en;
    logic       alone;
    logic       changed;
  } result_t;

  // One row of the directed table: either a register write or an event.
  typedef struct packed {
    bit                    is_wr;
    cmd_e                  op;
    bit                    lvl;
    bit                    lid;
    bit                    typed;   // result typed in below
    result_t               res;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  bpd_in_if  in_if ();
  bpd_out_if out_if ();
  bpd_cfg_if cfg_if ();

  base_presence_debouncer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Debounce model state and timing registers
  // --------------------------------------------------------------------------
  logic [15:0] attach_dly, detach_dly, window_len;
  status_e     cur_status;
  bit          det_on, edge_on, chk_pending;
  logic [15:0] chk_cnt, retry_cnt;

  result_t     pending_results[$];

  int unsigned items_sent = 0, results_seen = 0, cfg_writes = 0, fails = 0, cycles = 0;
  bit          no_idle;
  bit          pin_level;

  function automatic void model_reset();
    attach_dly  = 16'(ATTACH_RESET);
    detach_dly  = 16'(DETACH_RESET);
    window_len  = 16'(WINDOW_RESET);
    cur_status  = ST_UNKNOWN;
    det_on      = 1'b0;
    edge_on     = 1'b0;
    chk_pending = 1'b0;
    chk_cnt     = '0;
    retry_cnt   = '0;
  endfunction

  function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ATTACH: attach_dly = val;
      REG_DETACH: detach_dly = val;
      REG_WINDOW: window_len = val;
      default: ;
    endcase
  endfunction

  // Status update; an open retry window reschedules the check.
  function automatic void new_status(status_e s);
    if (retry_cnt != 0) begin
      chk_pending = 1'b1;
      chk_cnt     = retry_cnt;
    end
    cur_status = s;
  endfunction

  function automatic void switch_detect(bit on, bit lvl);
    det_on  = on;
    edge_on = on;
    if (on) begin
      new_status(lvl ? ST_CONNECTED : ST_DISCONNECTED);
    end else begin
      new_status(ST_UNKNOWN);
      chk_pending = 1'b0;
      chk_cnt     = '0;
    end
  endfunction

  function automatic result_t debounce_step(cmd_e op, bit lvl, bit lid);
    status_e prev;
    result_t r;
    prev = cur_status;
    case (op)
      CMD_TICK: begin
        if (retry_cnt != 0) retry_cnt = retry_cnt - 1'b1;
        if (chk_pending) begin
          if (chk_cnt <= 1) begin
            chk_cnt     = '0;
            chk_pending = 1'b0;
            if (det_on) begin
              new_status(lvl ? ST_CONNECTED : ST_DISCONNECTED);
              edge_on = 1'b1;
            end
          end else begin
            chk_cnt = chk_cnt - 1'b1;
          end
        end
      end
      CMD_EDGE: begin
        if (edge_on) begin
          edge_on     = 1'b0;
          chk_pending = 1'b1;
          chk_cnt     = (cur_status == ST_CONNECTED) ? detach_dly : attach_dly;
          retry_cnt   = window_len;
        end
      end
      CMD_POWER_UP, CMD_FORCE_RESET: switch_detect(1'b1, lvl);
      CMD_POWER_DOWN:                switch_detect(1'b0, lvl);
      CMD_FORCE_ATTACH: begin
        switch_detect(1'b0, lvl);
        new_status(ST_CONNECTED);
      end
      CMD_FORCE_DETACH: begin
        switch_detect(1'b0, lvl);
        new_status(ST_DISCONNECTED);
      end
      default: switch_detect(lid, lvl);
    endcase
    r.dock_state = cur_status;
    r.power_en   = (cur_status == ST_CONNECTED);
    r.alone      = (cur_status != ST_CONNECTED);
    r.changed    = (cur_status != prev);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idle lengths: mostly short, now and then a long pause
  // --------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: ready drops for random stretches unless idling is off.
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      stall_left   <= idle_len() - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: oldest expectation against each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("[%0t] result with nothing expected: st=%0d pwr=%0b alone=%0b chg=%0b",
                   $realtime, out_if.dock_state, out_if.base_power_enable,
                   out_if.standalone, out_if.status_changed);
      end else begin
        want = pending_results.pop_front();
        if (out_if.dock_state !== want.dock_state ||
            out_if.base_power_enable !== want.power_en ||
            out_if.standalone !== want.alone ||
            out_if.status_changed !== want.changed) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] mismatch st/pwr/alone/chg: exp %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                     $realtime, want.dock_state, want.power_en, want.alone,
                     want.changed, out_if.dock_state, out_if.base_power_enable,
                     out_if.standalone, out_if.status_changed);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // valid is left high after an accept so that a zero gap keeps the item
  // stream back to back; it is lowered when a gap follows or in drain().
  task automatic send_event(cmd_e op, bit lvl, bit lid, bit typed, result_t lit);
    int unsigned gap;
    result_t     r;
    gap = no_idle ? 0 : (($urandom_range(0, 99) < 55) ? 0 : idle_len());
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= op;
    in_if.presence_level <= lvl;
    in_if.lid_up         <= lid;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    r = debounce_step(op, lvl, lid);
    pending_results.push_back(typed ? lit : r);
    items_sent++;
  endtask

  // Wait for every result; the block is idle after.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    model_reg_write(idx, val);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic row_t ev(cmd_e op, bit lvl, bit lid);
    row_t w;
    w       = '0;
    w.op    = op;
    w.lvl   = lvl;
    w.lid   = lid;
    return w;
  endfunction

  function automatic row_t ev_lit(cmd_e op, bit lvl, bit lid, status_e st, bit chg);
    row_t w;
    w                = ev(op, lvl, lid);
    w.typed          = 1'b1;
    w.res.dock_state = st;
    w.res.power_en   = (st == ST_CONNECTED);
    w.res.alone      = (st != ST_CONNECTED);
    w.res.changed    = chg;
    return w;
  endfunction

  function automatic row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t w;
    w       = '0;
    w.is_wr = 1'b1;
    w.idx   = idx;
    w.val   = val;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    row_t        plan[$];
    row_t        row;
    logic [15:0] a_set, d_set, w_set;
    int unsigned pick;
    cmd_e        op;
    bit          lid;

    in_if.valid          <= 1'b0;
    in_if.command        <= CMD_TICK;
    in_if.presence_level <= 1'b0;
    in_if.lid_up         <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_ATTACH;
    cfg_if.data          <= '0;
    no_idle      = 1'b0;
    pin_level    = 1'b0;
    model_reset();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset timing values; the results here are plain to read.
    plan.push_back(ev_lit(CMD_TICK,         1'b0, 1'b0, ST_UNKNOWN, 1'b0));
    // edge before detection is armed: ignored
    plan.push_back(ev_lit(CMD_EDGE,         1'b1, 1'b0, ST_UNKNOWN, 1'b0));
    plan.push_back(ev_lit(CMD_POWER_UP,     1'b1, 1'b0, ST_CONNECTED, 1'b1));
    // force connected while already connected: no change reported
    plan.push_back(ev_lit(CMD_FORCE_ATTACH, 1'b0, 1'b0, ST_CONNECTED, 1'b0));
    plan.push_back(ev_lit(CMD_POWER_DOWN,   1'b1, 1'b0, ST_UNKNOWN, 1'b1));
    plan.push_back(ev_lit(CMD_FORCE_DETACH, 1'b1, 1'b0, ST_DISCONNECTED, 1'b1));
    plan.push_back(ev_lit(CMD_FORCE_RESET,  1'b0, 1'b0, ST_DISCONNECTED, 1'b0));
    plan.push_back(ev_lit(CMD_LID,          1'b1, 1'b0, ST_UNKNOWN, 1'b1));
    plan.push_back(ev_lit(CMD_LID,          1'b1, 1'b1, ST_CONNECTED, 1'b1));
    // zero delays; the write past the list must be dropped
    plan.push_back(wr(REG_ATTACH, 16'd0));
    plan.push_back(wr(REG_DETACH, 16'd0));
    plan.push_back(wr(REG_WINDOW, 16'd0));
    plan.push_back(wr(REG_UNUSED, 16'hFFFF));
    plan.push_back(ev(CMD_EDGE, 1'b0, 1'b0));
    plan.push_back(ev(CMD_TICK, 1'b0, 1'b0));     // zero delay fires on next tick
    // short delays with a retry window that outlives the first check
    plan.push_back(wr(REG_ATTACH, 16'd2));
    plan.push_back(wr(REG_DETACH, 16'd1));
    plan.push_back(wr(REG_WINDOW, 16'd4));
    plan.push_back(ev(CMD_EDGE, 1'b0, 1'b0));
    plan.push_back(ev(CMD_TICK, 1'b0, 1'b0));     // check counts down; it fires next tick and the window reschedules
    plan.push_back(ev(CMD_TICK, 1'b0, 1'b0));
    plan.push_back(ev(CMD_TICK, 1'b1, 1'b0));
    plan.push_back(ev(CMD_TICK, 1'b1, 1'b0));     // rescheduled check fires
    plan.push_back(ev(CMD_EDGE, 1'b1, 1'b0));
    plan.push_back(ev(CMD_POWER_DOWN, 1'b1, 1'b0)); // cancels pending check
    plan.push_back(ev(CMD_FORCE_RESET, 1'b0, 1'b0));
    plan.push_back(ev(CMD_EDGE, 1'b0, 1'b0));
    // force with window open leaves a check that fires with detection off
    plan.push_back(ev(CMD_FORCE_ATTACH, 1'b1, 1'b0));
    repeat (4) plan.push_back(ev(CMD_TICK, 1'b0, 1'b0));

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_wr) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_event(row.op, row.lvl, row.lid, row.typed, row.res);
      end
    end

    // Random part: one timing setting per phase
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          a_set = 16'(ATTACH_RESET);
          d_set = 16'(DETACH_RESET);
          w_set = 16'(WINDOW_RESET);
        end
        1: begin a_set = 16'hFFFF; d_set = 16'hFFFF; w_set = 16'hFFFF; end
        2: begin a_set = 16'd0; d_set = 16'd0; w_set = 16'd0; end
        3: begin a_set = 16'd1; d_set = 16'd0; w_set = 16'd2; end
        4: begin
          a_set = 16'($urandom_range(0, 6));
          d_set = 16'($urandom_range(0, 6));
          w_set = 16'($urandom_range(0, 8));
        end
        5: begin a_set = 16'd3; d_set = 16'hFFFF; w_set = 16'd0; end
        default: begin
          a_set = 16'($urandom_range(0, 25));
          d_set = 16'($urandom_range(0, 25));
          w_set = 16'($urandom_range(0, 40));
        end
      endcase
      drain();
      write_reg(REG_ATTACH, a_set);
      write_reg(REG_DETACH, d_set);
      write_reg(REG_WINDOW, w_set);
      no_idle = (p == 3 || p == 6);

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // pin stays put for a while, like a real contact
        if ($urandom_range(0, 99) < 15) pin_level = ~pin_level;
        lid  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          op = CMD_TICK;
        end else if (pick < 75) begin
          op = CMD_EDGE;
        end else if (pick < 82) begin
          // re-enable detection so edges keep getting through
          case ($urandom_range(0, 2))
            0:       op = CMD_POWER_UP;
            1:       op = CMD_FORCE_RESET;
            default: begin op = CMD_LID; lid = 1'b1; end
          endcase
        end else begin
          op = cmd_e'(3'($urandom_range(0, 7)));
        end
        send_event(op, pin_level, lid, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d events under %0d timing settings, %0d register writes",
             items_sent, NUM_PHASES + 3, cfg_writes);
    $display("results checked %0d, mismatches %0d, left over %0d",
             results_seen, fails, pending_results.size());
    if (fails == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
